>>> sv/chm_pkg.sv
package chm_pkg;
  localparam logic [2:0] ST_CREATED  = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_BADBKT   = 3'd5;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_HASH   = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam logic [8:0] BUCKET_COUNT_RESET = 9'd211;
endpackage

>>> sv/chm_mod.sv
// Iterative key mod n, one quotient bit per cycle (restoring division).
module chm_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] key,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [16:0] rem
);
  logic [31:0] key_r, key_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;

  always_comb begin
    key_nxt  = key_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r[16:0], key_r[31]};
    if (start) begin
      key_nxt = key;
      rem_nxt = '0;
      cnt_nxt = 6'd0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift one key bit in, subtract when it fits
      key_nxt = {key_r[30:0], 1'b0};
      rem_nxt = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    key_r <= key_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[16:0];
endmodule

>>> sv/chained_hash_map_engine_top.sv
// Chained hash map engine. A request is taken when start is high and busy is
// low; its one result appears on out_status/out_value for one cycle with
// out_valid, and must be taken then. A request keeps the block busy from
// acceptance until the engine is back in idle; the chain walk reads one node
// per cycle (the next link address goes straight to the node memory).
// Hashed-find mode first runs the key-mod-bucket_count divider. Bad-bucket
// and unused-mode requests skip the chain walk. Bucket heads sit in a memory
// with per-bucket valid flops, so there is no clearing pass after reset.
module chained_hash_map_engine_top #(
  parameter int MAX_BUCKETS = 256,
  parameter int POOL_NODES  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value_in,
  input  logic [7:0]  in_bucket,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_value,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int HW = $clog2(POOL_NODES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_NODE = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // memories
  logic [HW-1:0] head_mem [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] head_vld_r;
  logic [31:0]   key_mem  [POOL_NODES];
  logic [31:0]   val_mem  [POOL_NODES];
  logic [HW-1:0] link_mem [POOL_NODES];

  logic [8:0]    bcnt_r;
  logic [16:0]   nb;
  logic [2:0]    st_r, st_nxt;
  logic [1:0]    mode_r;
  logic [31:0]   key_r, val_r;
  logic [16:0]   bkt_r;
  logic [HW-1:0] cur_r, cur_nxt;
  logic [HW-1:0] used_r;
  logic [HW-1:0] steps_r;
  logic [HW-1:0] head_rd_r;
  logic          head_vld_rd_r;
  logic [31:0]   nkey_rd_r, nval_rd_r;
  logic [HW-1:0] nlink_rd_r;
  logic          ov_r;
  logic [2:0]    os_r;
  logic [31:0]   oval_r;
  logic          mod_start, mod_done;
  logic [16:0]   mod_rem;
  logic [HW-1:0] head_val;
  logic          hit;

  assign nb = (17'(bcnt_r) > 17'(MAX_BUCKETS)) ? 17'(MAX_BUCKETS) : 17'(bcnt_r);
  assign mod_start = start && !busy && in_mode == chm_pkg::MODE_HASH;

  chm_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .key(in_key),
    .divisor(nb), .done(mod_done), .rem(mod_rem)
  );

  assign head_val = head_vld_rd_r ? head_rd_r : '0;
  // key match on the node under compare
  assign hit = st_r == S_CMP && cur_r != '0 && nkey_rd_r == key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      bcnt_r <= chm_pkg::BUCKET_COUNT_RESET;
      used_r <= '0;
      head_vld_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= (st_r != S_IDLE) && (st_nxt == S_DONE);
      if (cfg_we) bcnt_r <= cfg_wdata;
      // per-state capture of the request and of the hashed bucket
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            mode_r <= in_mode;
            key_r  <= in_key;
            val_r  <= in_value_in;
            bkt_r  <= 17'(in_bucket);
          end
        end
        S_HASH: if (mod_done) bkt_r <= mod_rem;
        default: ;
      endcase
      // result and writes at completion
      if (st_r != S_IDLE && st_nxt == S_DONE) begin
        oval_r <= (hit && mode_r != chm_pkg::MODE_INSERT) ? nval_rd_r : '0;
        if (mode_r == chm_pkg::MODE_SPARE) os_r <= chm_pkg::ST_NOTFOUND;
        else if (nb == '0 || bkt_r >= nb) os_r <= chm_pkg::ST_BADBKT;
        else if (hit) begin
          if (mode_r == chm_pkg::MODE_INSERT) begin
            os_r <= chm_pkg::ST_UPDATED;
            val_mem[NW'(cur_r - HW'(1))] <= val_r;
          end else begin
            os_r <= chm_pkg::ST_FOUND;
          end
        end else if (mode_r != chm_pkg::MODE_INSERT) os_r <= chm_pkg::ST_NOTFOUND;
        else if (used_r >= HW'(POOL_NODES)) os_r <= chm_pkg::ST_FULL;
        else begin
          os_r <= chm_pkg::ST_CREATED;
          key_mem[NW'(used_r)]  <= key_r;
          val_mem[NW'(used_r)]  <= val_r;
          link_mem[NW'(used_r)] <= head_val;
          head_mem[BW'(bkt_r)]  <= used_r + HW'(1);
          head_vld_r[BW'(bkt_r)] <= 1'b1;
          used_r <= used_r + HW'(1);
        end
      end
    end
  end

  // registered memory reads
  always_ff @(posedge clk) begin
    head_rd_r     <= head_mem[BW'(bkt_r)];
    head_vld_rd_r <= head_vld_r[BW'(bkt_r)];
    nkey_rd_r     <= key_mem[NW'(cur_nxt - HW'(1))];
    nval_rd_r     <= val_mem[NW'(cur_nxt - HW'(1))];
    nlink_rd_r    <= link_mem[NW'(cur_nxt - HW'(1))];
  end

  // walk control
  always_comb begin
    st_nxt  = st_r;
    cur_nxt = cur_r;
    unique case (st_r)
      S_IDLE: if (start) begin
        if (in_mode == chm_pkg::MODE_HASH) st_nxt = S_HASH;
        else st_nxt = S_HEAD;
      end
      S_HASH: if (mod_done) st_nxt = S_HEAD;
      S_HEAD: begin
        if (mode_r == chm_pkg::MODE_SPARE || nb == '0 || bkt_r >= nb) st_nxt = S_DONE;
        else st_nxt = S_NODE;
      end
      S_NODE: begin
        cur_nxt = head_val;
        st_nxt  = (head_val == '0) ? S_DONE : S_CMP;
      end
      S_CMP: begin
        if (nkey_rd_r == key_r || nlink_rd_r == '0 ||
            steps_r >= HW'(POOL_NODES - 1)) st_nxt = S_DONE;
        else begin
          cur_nxt = nlink_rd_r;
          st_nxt  = S_CMP;
        end
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      steps_r <= '0;
    end else begin
      cur_r <= cur_nxt;
      if (st_r == S_NODE) steps_r <= '0;
      else if (st_r == S_CMP) steps_r <= steps_r + HW'(1);
    end
  end

  assign busy       = st_r != S_IDLE;
  assign out_valid  = ov_r;
  assign out_status = os_r;
  assign out_value  = oval_r;
endmodule

>>> sv/chm_checker.sv
module chm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [31:0] out_value
);
  // accepted request makes block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
  // results are single-cycle beats
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held");
  // value only on found
  a_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != chm_pkg::ST_FOUND |-> out_value == '0)
    else $error("stray value");
  // status in range
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= chm_pkg::ST_BADBKT) else $error("bad status");
endmodule

bind chained_hash_map_engine_top chm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_status(out_status), .out_value(out_value)
);

>>> sim/tb_chained_hash_map_engine_top.sv
module tb_chained_hash_map_engine_top;

  localparam int BUCKET_SLOTS = 256;
  localparam int NUM_NODES = 1024;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] val;
    logic [7:0]  bkt;
  } req_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] val;
  } resp_t;

  typedef struct {
    logic [31:0] key;
    logic [7:0]  bkt;
  } stored_key_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [31:0] in_key;
  logic [31:0] in_value_in;
  logic [7:0]  in_bucket;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_value;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;

  // table mirror
  logic [10:0] head_tbl [BUCKET_SLOTS];
  logic [31:0] node_keys [NUM_NODES];
  logic [31:0] node_vals [NUM_NODES];
  logic [10:0] node_next [NUM_NODES];
  int unsigned node_count;
  logic [8:0]  bucket_cfg;

  req_t          req_q[$];
  resp_t         resp_q[$];
  stored_key_t   key_book[$];
  req_t          drv_req;
  int            gap_left;
  bit            calm;
  int            err_count;
  int            beats_in;
  int            beats_out;
  int            status_seen [6];

  chained_hash_map_engine_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_key(in_key), .in_value_in(in_value_in),
    .in_bucket(in_bucket), .out_valid(out_valid), .out_status(out_status),
    .out_value(out_value), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned live_buckets();
    return (bucket_cfg > BUCKET_SLOTS) ? BUCKET_SLOTS : bucket_cfg;
  endfunction

  // walk one chain, return 1-based node handle or 0
  function automatic int unsigned find_node(int unsigned b, logic [31:0] key);
    int unsigned h;
    int unsigned steps;
    h = head_tbl[b];
    steps = 0;
    while (h != 0 && h <= NUM_NODES && steps < NUM_NODES) begin
      if (node_keys[h-1] == key) return h;
      h = node_next[h-1];
      steps++;
    end
    return 0;
  endfunction

  // apply one request to the mirror, return the expected response
  function automatic resp_t apply_req(req_t r);
    resp_t       res;
    int unsigned nb;
    int unsigned b;
    int unsigned h;
    nb = live_buckets();
    b = r.bkt;
    res.status = chm_pkg::ST_NOTFOUND;
    res.val = '0;
    if (r.mode == chm_pkg::MODE_SPARE) begin
      res.status = chm_pkg::ST_NOTFOUND;
    end else if (nb == 0) begin
      res.status = chm_pkg::ST_BADBKT;
    end else begin
      if (r.mode == chm_pkg::MODE_HASH) b = r.key % nb;
      if (b >= nb) begin
        res.status = chm_pkg::ST_BADBKT;
      end else if (r.mode == chm_pkg::MODE_INSERT) begin
        h = find_node(b, r.key);
        if (h != 0) begin
          node_vals[h-1] = r.val;
          res.status = chm_pkg::ST_UPDATED;
        end else if (node_count >= NUM_NODES) begin
          res.status = chm_pkg::ST_FULL;
        end else begin
          node_keys[node_count] = r.key;
          node_vals[node_count] = r.val;
          node_next[node_count] = head_tbl[b];
          node_count++;
          head_tbl[b] = 11'(node_count);
          res.status = chm_pkg::ST_CREATED;
        end
      end else begin
        h = find_node(b, r.key);
        if (h != 0) begin
          res.status = chm_pkg::ST_FOUND;
          res.val = node_vals[h-1];
        end
      end
    end
    return res;
  endfunction

  // random request, mostly well-formed, some reusing keys already stored
  function automatic req_t make_req(int unsigned nb);
    req_t        r;
    int unsigned pick;
    stored_key_t sk;
    r.mode = chm_pkg::MODE_INSERT;
    r.key = $urandom;
    r.val = $urandom;
    r.bkt = (nb > 0) ? 8'($urandom_range(nb - 1, 0)) : 8'($urandom);
    pick = $urandom_range(99, 0);
    if (pick < 65) begin
      if (nb > 0 && $urandom_range(2, 0) == 0) r.bkt = 8'(r.key % nb);
    end else if (pick < 90 && key_book.size() > 0) begin
      sk = key_book[$urandom_range(key_book.size() - 1, 0)];
      r.key = sk.key;
      r.bkt = sk.bkt;
      if (pick < 72) r.mode = chm_pkg::MODE_INSERT;
      else if (pick < 82) r.mode = chm_pkg::MODE_FIND;
      else r.mode = chm_pkg::MODE_HASH;
    end else if (pick < 95) begin
      r.mode = chm_pkg::MODE_SPARE;
    end else begin
      r.mode = 2'($urandom_range(2, 0));
      r.bkt = 8'($urandom);
    end
    if (r.mode == chm_pkg::MODE_INSERT && r.bkt < nb) begin
      sk.key = r.key;
      sk.bkt = r.bkt;
      key_book.push_back(sk);
    end
    return r;
  endfunction

  task automatic queue_req(logic [1:0] mode, logic [31:0] key, logic [31:0] val,
                           logic [7:0] bkt);
    req_t r;
    r.mode = mode;
    r.key = key;
    r.val = val;
    r.bkt = bkt;
    req_q.push_back(r);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (req_q.size() > 0 || start || resp_q.size() > 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_bucket_count(logic [8:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 9'($urandom);
    bucket_cfg = v;
  endtask

  task automatic random_phase(logic [8:0] count, int n);
    int unsigned nb;
    write_bucket_count(count);
    nb = live_buckets();
    repeat (n) req_q.push_back(make_req(nb));
  endtask

  // driver: one beat per start/!busy edge, random gaps between beats unless calm
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        resp_q.push_back(apply_req(drv_req));
        beats_in++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (req_q.size() > 0) begin
          drv_req = req_q.pop_front();
          in_mode <= drv_req.mode;
          in_key <= drv_req.key;
          in_value_in <= drv_req.val;
          in_bucket <= drv_req.bkt;
          start <= 1'b1;
          if (!calm && $urandom_range(3, 0) == 0) gap_left <= $urandom_range(4, 1);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    resp_t e;
    if (rst_n && out_valid) begin
      beats_out++;
      if (resp_q.size() == 0) begin
        $error("unexpected result beat: status=%0d value=%h", out_status, out_value);
        err_count++;
      end else begin
        e = resp_q.pop_front();
        if (out_status <= chm_pkg::ST_BADBKT) status_seen[out_status]++;
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          err_count++;
        end
        if (out_value !== e.val) begin
          $error("value_out: expected %h, got %h", e.val, out_value);
          err_count++;
        end
      end
    end
  end

  initial begin
    #40000000;
    $display("tb_chained_hash_map_engine_top: errors");
    $finish;
  end

  initial begin
    logic [31:0] k_hi;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = '0;
    in_key = '0;
    in_value_in = '0;
    in_bucket = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    calm = 1'b0;
    err_count = 0;
    beats_in = 0;
    beats_out = 0;
    node_count = 0;
    bucket_cfg = chm_pkg::BUCKET_COUNT_RESET;
    foreach (head_tbl[i]) head_tbl[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, each mode, each status but full at the reset count
    k_hi = 32'hFFFF_FFFF;
    queue_req(chm_pkg::MODE_INSERT, 32'h0, 32'h8000_0000, 8'd0);
    queue_req(chm_pkg::MODE_INSERT, k_hi, 32'h7FFF_FFFF, 8'd210);
    queue_req(chm_pkg::MODE_INSERT, k_hi, 32'h1234_5678, 8'(k_hi % 211));
    queue_req(chm_pkg::MODE_FIND, 32'h0, 32'h0, 8'd0);
    queue_req(chm_pkg::MODE_FIND, k_hi, 32'hFFFF_FFFF, 8'd210);
    queue_req(chm_pkg::MODE_HASH, k_hi, 32'h0, 8'd0);
    queue_req(chm_pkg::MODE_INSERT, 32'h0, 32'h5, 8'd0);
    queue_req(chm_pkg::MODE_FIND, 32'h0, 32'h0, 8'd0);
    queue_req(chm_pkg::MODE_FIND, 32'h0, 32'h0, 8'd1);
    queue_req(chm_pkg::MODE_INSERT, 32'h55, 32'h1, 8'd211);
    queue_req(chm_pkg::MODE_FIND, 32'h55, 32'h0, 8'd255);
    queue_req(chm_pkg::MODE_SPARE, k_hi, 32'hFFFF_FFFF, 8'hFF);
    queue_req(chm_pkg::MODE_HASH, 32'hDEAD_BEEF, 32'h0, 8'd0);

    // zero bucket count: everything but the spare mode is refused
    write_bucket_count(9'd0);
    queue_req(chm_pkg::MODE_INSERT, 32'h1, 32'h1, 8'd0);
    queue_req(chm_pkg::MODE_FIND, 32'h0, 32'h0, 8'd0);
    queue_req(chm_pkg::MODE_HASH, 32'h0, 32'h0, 8'd0);
    queue_req(chm_pkg::MODE_SPARE, 32'h0, 32'h0, 8'd0);

    // oversized count behaves as the full table
    write_bucket_count(9'h1FF);
    queue_req(chm_pkg::MODE_INSERT, k_hi, 32'hA5A5_A5A5, 8'd255);
    queue_req(chm_pkg::MODE_FIND, k_hi, 32'h0, 8'd255);
    queue_req(chm_pkg::MODE_HASH, k_hi, 32'h0, 8'd0);
    queue_req(chm_pkg::MODE_HASH, 32'h0, 32'h0, 8'd0);

    // random phases; enough fresh inserts to exhaust the pool
    random_phase(9'd256, 700);
    random_phase(9'd1, 25);
    random_phase(9'd97, 300);
    random_phase(9'd300, 200);
    random_phase(9'd2, 25);
    random_phase(9'd0, 15);
    random_phase(9'd211, 200);
    wait_idle();
    calm = 1'b1;
    random_phase(9'd256, 400);
    wait_idle();
    repeat (20) @(posedge clk);

    $display("%0d requests, %0d results, %0d nodes allocated", beats_in, beats_out,
             node_count);
    $display("created %0d updated %0d found %0d missing %0d full %0d bad-bucket %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (err_count == 0 && resp_q.size() == 0) begin
      $display("tb_chained_hash_map_engine_top: clean");
    end else begin
      $display("tb_chained_hash_map_engine_top: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/chm_pkg.sv
sv/chm_mod.sv
sv/chained_hash_map_engine_top.sv
sv/chm_checker.sv
sim/tb_chained_hash_map_engine_top.sv
